// ===== design/tcpe_pkg.sv =====
// Shared types and constants for the text cell pixel expander.
// Holds the queued job format, the pixel format and the default sizes.
// No dependencies.
`default_nettype none

package tcpe_pkg;

    // Field widths of the stream items.
    localparam int CODE_W  = 8;
    localparam int ROW_W   = 3;
    localparam int BITS_W  = 8;
    localparam int CELL_W  = 12;
    localparam int ATTR_W  = 8;
    localparam int COLS_W  = 7;
    localparam int COLOR_W = 4;
    localparam int PX_W    = 10;
    localparam int PY_W    = 15;

    // Packed stream widths (tdata rounded up to whole bytes).
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Defaults for the top-level parameters.
    localparam int MAX_CELLS_DEF   = 4096;
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset value.
    localparam logic [COLS_W-1:0] COLS_RESET = 7'd40;

    // Item kinds carried in tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // One job between the front and the back end.
    typedef struct packed {
        logic                is_render;
        logic                blank;
        logic [CODE_W-1:0]   code;
        logic [ROW_W-1:0]    row;
        logic [BITS_W-1:0]   bits;
        logic [CELL_W-1:0]   cell_y;
        logic [COLS_W-1:0]   cell_x;
        logic [COLOR_W-1:0]  fg;
        logic [COLOR_W-1:0]  bg;
    } t_job;

    // One emitted pixel.
    typedef struct packed {
        logic                last;
        logic [COLOR_W-1:0]  color;
        logic [PY_W-1:0]     y;
        logic [PX_W-1:0]     x;
    } t_pixel;

endpackage

`default_nettype wire

// ===== design/text_cell_pixel_expander.sv =====
// Top level of the text-mode character generator.
// Ties the front end, the job queue and the pixel back end; uses tcpe_pkg.
`default_nettype none

// A load beat (tuser = 0) writes one 8-bit row of a glyph into the font RAM;
// a render beat (tuser = 1) expands one screen cell into 64 pixel beats, top
// row first and left pixel first, with tlast on the 64th. The front end
// passes loads to the queue and locates a render cell with a bit-serial
// divider; a queue of QUEUE_DEPTH jobs lets it run ahead of the back end.
// The back end sets the rate: it writes a load on dispatch; a cell reads
// its first glyph row, then emits one pixel per cycle while the output
// does not stall, the next row prefetched through the RAM's registered
// read port. The font RAM has no clearing pass: render only glyph rows
// that were loaded. Write the column register only while idle.
module text_cell_pixel_expander
    import tcpe_pkg::*;
#(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [COLS_W-1:0]     i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: char_code[7:0], glyph_row[10:8], glyph_bits[18:11],
    // cell_number[30:19], attribute[38:31], zero fill[39]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[0]
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: pixel_x[9:0], pixel_y[24:10], palette_index[28:25], zero fill[31:29]
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    output logic                       m_axis_tlast
);

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    t_job    q_wr_job;
    t_job    q_rd_job;
    t_pixel  pixel;

    // Front end: filtering and cell location.
    tcpe_front #(
        .MAX_CELLS   (MAX_CELLS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (q_wr_job)
    );

    // Job queue.
    tcpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_wr_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_rd_job),
        .o_empty (q_empty)
    );

    // Back end: font RAM and pixel expansion.
    tcpe_back #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_rd_job),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pixel   (pixel)
    );

    // Pack the output beat.
    assign m_axis_tdata = {3'b000, pixel.color, pixel.y, pixel.x};
    assign m_axis_tlast = pixel.last;

endmodule

`default_nettype wire

// ===== design/tcpe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// The read data holds while no read is enabled. No dependencies.
`default_nettype none

module tcpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/tcpe_front.sv =====
// Front end: accepts stream items, filters them and locates render cells.
// Holds the column register and a bit-serial divider. Uses tcpe_pkg.
`default_nettype none

module tcpe_front
    import tcpe_pkg::*;
#(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [COLS_W-1:0]     i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_cmd,
    input  wire logic [S_TDATA_W-1:0]  i_data,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output t_job                       o_q_job
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } t_front_state;

    localparam int STEPS = CELL_W;

    t_front_state        r_state;
    logic [COLS_W-1:0]   r_cfg_cols;
    logic [COLS_W-1:0]   r_cols;
    logic [CELL_W-1:0]   r_dividend;
    logic [COLS_W-1:0]   r_rem;
    logic [3:0]          r_cnt;
    t_job                r_job;

    logic [CODE_W-1:0]   in_code;
    logic [ROW_W-1:0]    in_row;
    logic [BITS_W-1:0]   in_bits;
    logic [CELL_W-1:0]   in_cell;
    logic [ATTR_W-1:0]   in_attr;
    logic                accept;
    logic                code_ok;
    logic                cell_ok;
    logic [COLS_W:0]     trial;
    logic                trial_ge;
    t_job                in_job;

    // Unpack the input beat, lowest field first.
    assign in_code = i_data[7:0];
    assign in_row  = i_data[10:8];
    assign in_bits = i_data[18:11];
    assign in_cell = i_data[30:19];
    assign in_attr = i_data[38:31];

    assign o_ready = (r_state == ST_IDLE) && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign code_ok = ({1'b0, in_code} < 9'(GLYPH_COUNT));
    assign cell_ok = ({5'b0, in_cell} < 17'(MAX_CELLS));

    // Job built straight from the beat; a load goes out unchanged.
    always_comb begin
        in_job           = '0;
        in_job.is_render = (i_cmd == CMD_RENDER);
        in_job.blank     = !code_ok;
        in_job.code      = in_code;
        in_job.row       = in_row;
        in_job.bits      = in_bits;
        in_job.fg        = in_attr[7:4];
        in_job.bg        = in_attr[3:0];
    end

    // One restoring division step per cycle.
    assign trial    = {r_rem, r_dividend[CELL_W-1]};
    assign trial_ge = (trial >= {1'b0, r_cols});

    // Queue write: loads in the accept cycle, renders once located.
    always_comb begin
        o_q_push = 1'b0;
        o_q_job  = in_job;
        if (r_state == ST_PUSH) begin
            o_q_push = !i_q_full;
            o_q_job  = r_job;
        end else if (accept && (i_cmd == CMD_LOAD) && code_ok) begin
            o_q_push = 1'b1;
        end
    end

    // Column register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            r_cfg_cols <= i_cfg_data;
        end
    end

    // Control sequence of the front end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (i_cmd == CMD_RENDER) && cell_ok) begin
                        r_state <= ST_DIV;
                        r_cnt   <= '0;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(STEPS - 1)) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Divider datapath; the quotient shifts in behind the dividend.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && accept) begin
            r_job      <= in_job;
            r_dividend <= in_cell;
            r_rem      <= '0;
            r_cols     <= (r_cfg_cols == '0) ? 7'd1 : r_cfg_cols;
        end else if (r_state == ST_DIV) begin
            r_dividend <= {r_dividend[CELL_W-2:0], trial_ge};
            r_rem      <= trial_ge ? COLS_W'(trial - {1'b0, r_cols}) : trial[COLS_W-1:0];
        end else if ((r_state == ST_PUSH) && !i_q_full) begin
            r_job.cell_y <= r_dividend;
            r_job.cell_x <= r_rem;
        end
        if (r_state == ST_DIV && r_cnt == 4'(STEPS - 1)) begin
            r_job.cell_y <= {r_dividend[CELL_W-2:0], trial_ge};
            r_job.cell_x <= trial_ge ? COLS_W'(trial - {1'b0, r_cols})
                                     : trial[COLS_W-1:0];
        end
    end

    // The remainder of a finished division is below the divisor.
    a_rem_below_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> (r_rem < r_cols))
        else $error("front: remainder not below column count");

    // The divider runs exactly its number of steps before the push.
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_PUSH) |-> (r_cnt == 4'(STEPS)))
        else $error("front: division step count wrong");

endmodule

`default_nettype wire

// ===== design/tcpe_queue.sv =====
// Small job queue between the front and the back end, in flip-flops.
// Uses tcpe_pkg for the job type.
`default_nettype none

module tcpe_queue
    import tcpe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_job       i_job,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_job       o_job,
    output logic       o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    // Neither side may overrun the queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue: pop while empty");

endmodule

`default_nettype wire

// ===== design/tcpe_back.sv =====
// Back end: writes glyph rows and expands render jobs into pixels.
// Owns the font RAM (tcpe_ram) and the output register. Uses tcpe_pkg.
`default_nettype none

module tcpe_back
    import tcpe_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_job       i_job,
    input  wire logic  i_q_empty,
    output logic       o_q_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_pixel     o_pixel
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PRIME = 3'b010,
        ST_RUN   = 3'b100
    } t_back_state;

    localparam int DEPTH = GLYPH_COUNT * 8;
    localparam int AW    = $clog2(DEPTH);

    t_back_state         r_state;
    t_job                r_job;
    logic [ROW_W-1:0]    r_v;
    logic [ROW_W-1:0]    r_h;
    logic [BITS_W-1:0]   r_line;
    logic                r_out_valid;
    t_pixel              r_out;

    logic                adv;
    logic                row_end;
    logic                wr_en;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_row;
    logic [CODE_W-1:0]   rd_code;
    logic [AW-1:0]       rd_addr;
    logic [BITS_W-1:0]   rd_data;
    t_pixel              pix;

    // Job dispatch from the queue.
    assign o_q_pop = (r_state == ST_IDLE) && !i_q_empty;
    assign wr_en   = o_q_pop && !i_job.is_render;
    assign adv     = (r_state == ST_RUN) && (!r_out_valid || i_ready);
    assign row_end = (r_h == 3'd7);

    // Glyph row prefetch: row 0 at dispatch, row 1 when primed, then two ahead.
    always_comb begin
        rd_en   = 1'b0;
        rd_row  = '0;
        rd_code = r_job.code;
        if (o_q_pop && i_job.is_render) begin
            rd_en   = 1'b1;
            rd_code = i_job.code;
        end else if (r_state == ST_PRIME) begin
            rd_en  = 1'b1;
            rd_row = 3'd1;
        end else if (adv && row_end && (r_v < 3'd6)) begin
            rd_en  = 1'b1;
            rd_row = r_v + 3'd2;
        end
    end
    assign rd_addr = AW'({rd_code, rd_row});

    tcpe_ram #(
        .WIDTH (BITS_W),
        .DEPTH (DEPTH)
    ) u_font (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'({i_job.code, i_job.row})),
        .i_wr_data (i_job.bits),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Current pixel from the row shift position.
    always_comb begin
        pix.x     = {r_job.cell_x, r_h};
        pix.y     = {r_job.cell_y, r_v};
        pix.color = r_line[~r_h] ? r_job.fg : r_job.bg;
        pix.last  = (r_v == 3'd7) && row_end;
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v     <= '0;
            r_h     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop && i_job.is_render) begin
                        r_state <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    r_state <= ST_RUN;
                    r_v     <= '0;
                    r_h     <= '0;
                end
                ST_RUN: begin
                    if (adv) begin
                        r_h <= r_h + 3'd1;
                        if (row_end) begin
                            r_v <= r_v + 3'd1;
                            if (r_v == 3'd7) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Job and glyph line registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_job.is_render) begin
            r_job <= i_job;
        end
        if ((r_state == ST_PRIME) || (adv && row_end)) begin
            r_line <= r_job.blank ? '0 : rd_data;
        end
    end

    // Output register; a new pixel enters as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= pix;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

    // Pixel emission starts only after the first glyph row is primed.
    a_run_after_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_RUN) |-> $past(r_state == ST_PRIME))
        else $error("back: pixel run without primed glyph row");

endmodule

`default_nettype wire

// ===== dv/text_cell_pixel_expander_tb.sv =====
// Self-checking testbench for the text cell pixel expander: drives glyph loads and
// cell renders with random gaps and stalls, predicts every pixel beat and checks it.
// Depends on tcpe_pkg and the text_cell_pixel_expander top level.
module text_cell_pixel_expander_tb
    import tcpe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int CELL_LIMIT      = MAX_CELLS_DEF;
    localparam int REPORT_LIMIT    = 10;

    // Input beat layout, first field in the lowest bits.
    typedef struct packed {
        logic                fill;
        logic [ATTR_W-1:0]   attr;
        logic [CELL_W-1:0]   cell_num;
        logic [BITS_W-1:0]   bits;
        logic [ROW_W-1:0]    row;
        logic [CODE_W-1:0]   code;
    } t_cell_beat;

    // Tracks the font and column setting and holds the pixels still owed by the block.
    class t_pixel_scoreboard;
        logic [BITS_W-1:0] font_rows [0:2047];
        logic [COLS_W-1:0] cols;
        t_pixel            owed_pixels [$];
        int                mismatches;
        int                pixels_checked;

        function new();
            foreach (font_rows[i]) font_rows[i] = '0;
            cols = COLS_RESET;
            mismatches = 0;
            pixels_checked = 0;
        endfunction

        function void set_cols(logic [COLS_W-1:0] value);
            cols = value;
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        // A load updates the font; a render queues its 64 pixels in scan order.
        function void note_beat(logic cmd, t_cell_beat beat);
            int          eff_cols;
            int          base_x;
            int          base_y;
            logic [31:0] coord;
            logic [7:0]  line;
            t_pixel      px;
            if (cmd == CMD_LOAD) begin
                font_rows[{beat.code, beat.row}] = beat.bits;
                return;
            end
            if (int'(beat.cell_num) >= CELL_LIMIT) return;
            // A column count of zero behaves as one.
            eff_cols = (cols == 0) ? 1 : int'(cols);
            base_x = (int'(beat.cell_num) % eff_cols) * 8;
            base_y = (int'(beat.cell_num) / eff_cols) * 8;
            for (int v = 0; v < 8; v++) begin
                line = font_rows[{beat.code, 3'(v)}];
                for (int h = 0; h < 8; h++) begin
                    coord    = base_x + h;
                    px.x     = coord[PX_W-1:0];
                    coord    = base_y + v;
                    px.y     = coord[PY_W-1:0];
                    px.color = line[7-h] ? beat.attr[7:4] : beat.attr[3:0];
                    px.last  = (v == 7) && (h == 7);
                    owed_pixels = {owed_pixels, px};
                end
            end
        endfunction

        function void report(string what, t_pixel want, t_pixel got);
            if (mismatches < REPORT_LIMIT) begin
                $display("%s: expected x=%0d y=%0d color=%0d last=%0b,",
                         what, want.x, want.y, want.color, want.last);
                $display("    got x=%0d y=%0d color=%0d last=%0b",
                         got.x, got.y, got.color, got.last);
            end
            mismatches++;
        endfunction

        // Compare one output beat with the oldest owed pixel.
        function void check_pixel(logic [M_TDATA_W-1:0] data, logic last);
            t_pixel got;
            t_pixel want;
            got = t_pixel'({last, data[PX_W+PY_W+COLOR_W-1:0]});
            if (owed_pixels.size() == 0) begin
                report("unexpected pixel beat", '0, got);
                return;
            end
            want = owed_pixels.pop_front();
            pixels_checked++;
            if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                    got.last !== want.last) begin
                report("pixel mismatch", want, got);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [COLS_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: char_code, glyph_row, glyph_bits, cell_number, attribute, zero fill
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // tuser: cmd
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: pixel_x, pixel_y, palette_index, zero fill
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    t_pixel_scoreboard pix_sb = new();

    // Sender and receiver idling controls shared between processes.
    bit   tx_quiet = 1'b0;
    bit   rx_quiet = 1'b0;
    bit   hold_req = 1'b0;
    int   beats_sent = 0;
    int   renders_sent = 0;
    int   settings_used = 0;

    // Glyphs whose eight rows have all been loaded may be rendered.
    logic [7:0] rows_loaded [0:255];
    bit         glyph_ready [0:255];
    logic [7:0] ready_codes [$];

    text_cell_pixel_expander dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Output monitor: every accepted pixel beat is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            pix_sb.check_pixel(m_axis_tdata, m_axis_tlast);
        end
    end

    // Mostly short gaps, a few long ones, none while quiet.
    function automatic int gap_length(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin : receiver
        int n;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = gap_length(rx_quiet);
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(negedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // Present one beat and hold it until the block takes it.
    task automatic send_beat(logic cmd, t_cell_beat beat);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        pix_sb.note_beat(cmd, beat);
        beats_sent++;
    endtask

    task automatic pause_tx(int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed pixel is out and loads have drained.
    task automatic settle_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pix_sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cols(logic [COLS_W-1:0] value);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        pix_sb.set_cols(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Loads carry random values in the fields they ignore.
    task automatic send_load(logic [7:0] code, logic [2:0] row, logic [7:0] bits);
        t_cell_beat beat;
        beat.fill     = 1'b0;
        beat.attr     = ATTR_W'($urandom_range(0, 255));
        beat.cell_num = CELL_W'($urandom_range(0, 4095));
        beat.bits     = bits;
        beat.row      = row;
        beat.code     = code;
        send_beat(CMD_LOAD, beat);
        rows_loaded[code][row] = 1'b1;
        if (&rows_loaded[code] && !glyph_ready[code]) begin
            glyph_ready[code] = 1'b1;
            ready_codes = {ready_codes, code};
        end
        pause_tx(gap_length(tx_quiet));
    endtask

    // Renders carry random values in the row and bits fields they ignore.
    task automatic send_render(logic [7:0] code, logic [11:0] cell_no, logic [7:0] attr);
        t_cell_beat beat;
        beat.fill     = 1'b0;
        beat.attr     = attr;
        beat.cell_num = cell_no;
        beat.bits     = BITS_W'($urandom_range(0, 255));
        beat.row      = ROW_W'($urandom_range(0, 7));
        beat.code     = code;
        send_beat(CMD_RENDER, beat);
        renders_sent++;
        pause_tx(gap_length(tx_quiet));
    endtask

    function automatic logic [7:0] random_bits();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // Cells lean toward both ends of the screen.
    function automatic logic [11:0] pick_cell();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'd4095;
            2: return 12'($urandom_range(4000, 4095));
            3: return 12'($urandom_range(0, 127));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    endfunction

    // Mostly whole glyph loads followed by renders, with renders and stray row loads mixed in.
    task automatic random_traffic(int n);
        int         done;
        int         r;
        int         reps;
        bit         reversed;
        logic [7:0] code;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                code = 8'($urandom_range(0, 255));
                reversed = $urandom_range(0, 1);
                for (int i = 0; i < 8; i++) begin
                    send_load(code, reversed ? 3'(7 - i) : 3'(i), random_bits());
                end
                reps = $urandom_range(1, 3);
                for (int i = 0; i < reps; i++) begin
                    send_render(code, pick_cell(), 8'($urandom_range(0, 255)));
                end
                done += 8 + reps;
            end else if (r < 82) begin
                send_render(pick_code(), pick_cell(), 8'($urandom_range(0, 255)));
                done++;
            end else begin
                send_load(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), random_bits());
                done++;
            end
        end
    endtask

    // Stimulus: reset, directed cells, then random phases over several column settings.
    initial begin : stimulus
        logic [7:0]        pattern [0:7];
        logic [COLS_W-1:0] col_settings [0:5];
        pattern = '{8'hff, 8'h00, 8'h80, 8'h01, 8'haa, 8'h55, 8'h0f, 8'hf0};
        col_settings = '{7'd1, 7'd80, 7'd0, 7'd127, 7'($urandom_range(2, 79)), 7'd40};
        foreach (rows_loaded[i]) begin
            rows_loaded[i] = '0;
            glyph_ready[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: two full glyphs, then cells at the screen corners and the row
        // boundary under the reset column count, with extreme attributes.
        for (int i = 0; i < 8; i++) send_load(8'h00, 3'(i), pattern[i]);
        for (int i = 0; i < 8; i++) send_load(8'hff, 3'(i), ~pattern[i]);
        send_render(8'h00, 12'd0, 8'hf0);
        send_render(8'hff, 12'd4095, 8'h0f);
        send_render(8'h00, 12'd39, 8'ha5);
        send_render(8'hff, 12'd40, 8'h5a);
        send_render(8'h00, 12'd4095, 8'hff);
        send_render(8'hff, 12'd1234, 8'h00);

        for (int phase = 0; phase < 6; phase++) begin
            write_cols(col_settings[phase]);
            tx_quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
            rx_quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // Receiver stalls for a long time while cells keep coming.
                tx_quiet = 1'b1;
                hold_req = 1'b1;
                for (int i = 0; i < 10; i++) begin
                    send_render(pick_code(), pick_cell(), 8'($urandom_range(0, 255)));
                end
                tx_quiet = 1'b0;
            end
            random_traffic(ITEMS_PER_PHASE / 2);
            if (phase == 4) begin
                // Sender waits for the block to drain before going on.
                settle_idle();
            end
            random_traffic(ITEMS_PER_PHASE / 2);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pix_sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d beats (%0d renders) over %0d column settings, 0 and 127 too.",
                 beats_sent, renders_sent, settings_used);
        $display("Checked %0d pixel beats under random gaps, stalls and a long hold-off.",
                 pix_sb.pixels_checked);
        if (pix_sb.mismatches == 0 && pix_sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d pixel errors", pix_sb.mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout: no beat accepted for %0d cycles, %0d pixels still owed",
                 WATCHDOG_LIMIT, pix_sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcpe_pkg.sv
design/tcpe_ram.sv
design/tcpe_front.sv
design/tcpe_queue.sv
design/tcpe_back.sv
design/text_cell_pixel_expander.sv
dv/text_cell_pixel_expander_tb.sv
